>>> design/hsdo_pkg.sv
`default_nettype none
package hsdo_pkg;

  localparam int MODE_W   = 2;
  localparam int ENTRY_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT = 2'd2;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic accept;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic dump_more;
    logic out_free;
  } ctrl_stat_t;

endpackage
`default_nettype wire

>>> design/hsdo_channels.sv
`default_nettype none
interface hsdo_item_if;
  logic                           valid;
  logic                           ready;
  logic [hsdo_pkg::MODE_W-1:0]    mode;
  logic [hsdo_pkg::ENTRY_W-1:0]   entry;

  modport source (output valid, mode, entry, input ready);
  modport sink   (input valid, mode, entry, output ready);
endinterface

interface hsdo_result_if #(
  parameter int PW = 5
);
  logic                           valid;
  logic                           ready;
  logic [hsdo_pkg::STATUS_W-1:0]  status;
  logic [hsdo_pkg::ENTRY_W-1:0]   value;
  logic [PW-1:0]                  position;
  logic                           last;

  modport source (output valid, status, value, position, last, input ready);
  modport sink   (input valid, status, value, position, last, output ready);
endinterface
`default_nettype wire

>>> design/history_stack_drop_oldest_core.sv
`default_nettype none
// Bounded history stack of 32-bit entries held in a DEPTH-slot ring memory. A push stores
// the entry on top; when the count has reached the capacity register (0 acts as 1, values
// above DEPTH act as DEPTH) the oldest entry is dropped and returned with status 2. A pop
// returns the newest entry, a dump returns all entries newest first with their index from
// the oldest, last set on index 0; pop or dump of an empty stack gives one result with
// status 1. Mode 3 is taken and ignored. The entry memory has a registered read port, so each
// item first issues its read and then emits its results in turn, each as the output register
// is free. The next item is taken once the last result is in the output register, even if
// that result is stalled.
module history_stack_drop_oldest_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [hsdo_pkg::CFG_W-1:0] cfg_data,
  hsdo_item_if.sink                       item,
  hsdo_result_if.source                   result
);

  localparam int CW = $clog2(DEPTH + 1);

  hsdo_pkg::ctrl_cmd_t  cmd;
  hsdo_pkg::ctrl_stat_t st;
  logic                 in_ready;
  logic                 out_valid;
  logic [CW-1:0]        out_position;

  hsdo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hsdo_datapath #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .mode         (item.mode),
    .entry        (item.entry),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (result.ready),
    .out_status   (result.status),
    .out_value    (result.value),
    .out_position (out_position),
    .out_last     (result.last)
  );

  assign item.ready      = in_ready;
  assign result.valid    = out_valid;
  assign result.position = out_position;

endmodule
`default_nettype wire

>>> design/hsdo_ctrl.sv
`default_nettype none
module hsdo_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hsdo_pkg::ctrl_stat_t st,
  output hsdo_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && st.item_ok) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (!st.dump_more) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

  a_emit_only_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == S_EXEC)
    else $error("emit outside execute state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> !in_ready)
    else $error("input ready while item in progress");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_EXEC)
    else $error("accepted item did not start execution");

endmodule
`default_nettype wire

>>> design/hsdo_datapath.sv
`default_nettype none
module hsdo_datapath #(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [hsdo_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [hsdo_pkg::MODE_W-1:0]       mode,
  input  wire logic [hsdo_pkg::ENTRY_W-1:0]      entry,
  input  wire hsdo_pkg::ctrl_cmd_t               cmd,
  output hsdo_pkg::ctrl_stat_t                   st,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [hsdo_pkg::STATUS_W-1:0]          out_status,
  output logic [hsdo_pkg::ENTRY_W-1:0]           out_value,
  output logic [CW-1:0]                          out_position,
  output logic                                   out_last
);

  localparam int SW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUMW = CW + 1;
  localparam int EW   = (CW > hsdo_pkg::CFG_W) ? CW : hsdo_pkg::CFG_W;

  logic [hsdo_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [hsdo_pkg::ENTRY_W-1:0] rd_data;

  logic [CW-1:0]                  count;
  logic [SW-1:0]                  oldest;
  logic [hsdo_pkg::CFG_W-1:0]     capacity;
  logic [hsdo_pkg::MODE_W-1:0]    op;
  logic [hsdo_pkg::ENTRY_W-1:0]   entry_q;
  logic [CW-1:0]                  idx;

  logic [EW-1:0]                  cap_eff;
  logic                           full;
  logic                           empty;
  logic [CW-1:0]                  top_off;
  logic                           rd_en;
  logic [SW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [SW-1:0]                  wr_addr;
  logic                           dump_more;

  logic [hsdo_pkg::STATUS_W-1:0]  res_status;
  logic [hsdo_pkg::ENTRY_W-1:0]   res_value;
  logic [CW-1:0]                  res_position;
  logic                           res_last;
  logic [CW-1:0]                  count_next;
  logic [SW-1:0]                  oldest_next;

  function automatic logic [SW-1:0] slot(input logic [SW-1:0] base, input logic [CW-1:0] off);
    logic [SUMW-1:0] sum;
    sum = SUMW'(base) + SUMW'(off);
    if (sum >= SUMW'(DEPTH)) begin
      sum = sum - SUMW'(DEPTH);
    end
    return sum[SW-1:0];
  endfunction

  always_comb begin
    if (capacity == '0) begin
      cap_eff = EW'(1);
    end else if (EW'(capacity) > EW'(DEPTH)) begin
      cap_eff = EW'(DEPTH);
    end else begin
      cap_eff = EW'(capacity);
    end
  end

  assign empty     = (count == '0);
  assign full      = !empty && (EW'(count) >= cap_eff);
  assign top_off   = empty ? '0 : count - CW'(1);
  assign dump_more = (op == hsdo_pkg::MODE_DUMP) && !empty && (idx != '0);

  assign st.item_ok   = (mode == hsdo_pkg::MODE_PUSH) || (mode == hsdo_pkg::MODE_POP) ||
                        (mode == hsdo_pkg::MODE_DUMP);
  assign st.dump_more = dump_more;
  assign st.out_free  = !out_valid || out_ready;

  assign rd_en   = cmd.accept || (cmd.emit && dump_more);
  assign rd_addr = cmd.accept ?
                   ((mode == hsdo_pkg::MODE_PUSH) ? oldest : slot(oldest, top_off)) :
                   slot(oldest, idx - CW'(1));
  assign wr_en   = cmd.emit && (op == hsdo_pkg::MODE_PUSH);
  assign wr_addr = slot(oldest, count);

  always_comb begin
    res_status   = hsdo_pkg::ST_OK;
    res_value    = '0;
    res_position = '0;
    res_last     = 1'b1;
    count_next   = count;
    oldest_next  = oldest;
    case (op)
      hsdo_pkg::MODE_PUSH: begin
        if (full) begin
          res_status   = hsdo_pkg::ST_EVICT;
          res_value    = rd_data;
          res_position = count;
          oldest_next  = slot(oldest, CW'(1));
        end else begin
          count_next   = count + CW'(1);
          res_position = count_next;
        end
      end
      hsdo_pkg::MODE_POP: begin
        if (empty) begin
          res_status = hsdo_pkg::ST_EMPTY;
        end else begin
          res_value    = rd_data;
          count_next   = top_off;
          res_position = top_off;
        end
      end
      hsdo_pkg::MODE_DUMP: begin
        if (empty) begin
          res_status = hsdo_pkg::ST_EMPTY;
        end else begin
          res_value    = rd_data;
          res_position = idx;
          res_last     = (idx == '0);
        end
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= entry_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= mode;
      entry_q <= entry;
      idx     <= top_off;
    end else if (cmd.emit && dump_more) begin
      idx <= idx - CW'(1);
    end
    if (cmd.emit) begin
      out_status   <= res_status;
      out_value    <= res_value;
      out_position <= res_position;
      out_last     <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      oldest    <= '0;
      capacity  <= hsdo_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.emit) begin
        count     <= count_next;
        oldest    <= oldest_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_emit_space: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && op == hsdo_pkg::MODE_PUSH && !full |=> count == $past(count) + CW'(1))
    else $error("push without eviction did not grow count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && op == hsdo_pkg::MODE_POP && !empty
      |=> count == $past(count) - CW'(1) && $stable(oldest))
    else $error("pop did not shrink count");

endmodule
`default_nettype wire

>>> sim/tb_history_stack_drop_oldest_core.sv
`default_nettype none
module tb_history_stack_drop_oldest_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int POS_W = 5;
  localparam int LIMIT_CYCLES = 300000;
  localparam int LONG_HOLD = 300;
  localparam logic [hsdo_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic [hsdo_pkg::MODE_W-1:0]  mode;
    logic [hsdo_pkg::ENTRY_W-1:0] entry;
  } stack_op_t;

  typedef struct packed {
    logic [hsdo_pkg::STATUS_W-1:0] status;
    logic [hsdo_pkg::ENTRY_W-1:0]  value;
    logic [POS_W-1:0]              position;
    logic                          last;
  } stack_res_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [hsdo_pkg::CFG_W-1:0] cfg_data;

  hsdo_item_if            item_ch ();
  hsdo_result_if #(POS_W) res_ch ();

  history_stack_drop_oldest_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .item    (item_ch),
    .result  (res_ch)
  );

  always #10 clk = ~clk;

  // shadow of the stack
  logic [hsdo_pkg::ENTRY_W-1:0] hist_mem [DEPTH];
  logic [POS_W-1:0]             hist_count;
  logic [3:0]                   hist_oldest;
  logic [hsdo_pkg::CFG_W-1:0]   hist_cap;

  stack_op_t  op_q [$];
  stack_res_t expected_q [$];
  int errors = 0;

  task automatic report_error(input string msg);
    if (errors < 40) $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [3:0] ring_slot(input logic [POS_W-1:0] off);
    logic [3:0] s;
    s = hist_oldest + off[3:0];
    return s;
  endfunction

  task automatic predict_stack(input logic [hsdo_pkg::MODE_W-1:0] md,
                               input logic [hsdo_pkg::ENTRY_W-1:0] word);
    stack_res_t r;
    logic [POS_W-1:0] lim;
    logic [POS_W-1:0] idx;
    lim = (hist_cap == 0) ? 5'd1 : ((hist_cap > DEPTH) ? 5'(DEPTH) : hist_cap);
    case (md)
      hsdo_pkg::MODE_PUSH: begin
        if (hist_count >= lim && hist_count != 0) begin
          r = '{status: hsdo_pkg::ST_EVICT, value: hist_mem[hist_oldest],
                position: hist_count, last: 1'b1};
          hist_oldest = hist_oldest + 4'd1;
          hist_mem[ring_slot(hist_count - 5'd1)] = word;
        end else begin
          hist_mem[ring_slot(hist_count)] = word;
          hist_count = hist_count + 5'd1;
          r = '{status: hsdo_pkg::ST_OK, value: '0, position: hist_count, last: 1'b1};
        end
        expected_q.push_back(r);
      end
      hsdo_pkg::MODE_POP: begin
        if (hist_count == 0) begin
          r = '{status: hsdo_pkg::ST_EMPTY, value: '0, position: '0, last: 1'b1};
        end else begin
          r.value = hist_mem[ring_slot(hist_count - 5'd1)];
          hist_count = hist_count - 5'd1;
          r.status = hsdo_pkg::ST_OK;
          r.position = hist_count;
          r.last = 1'b1;
        end
        expected_q.push_back(r);
      end
      hsdo_pkg::MODE_DUMP: begin
        if (hist_count == 0) begin
          r = '{status: hsdo_pkg::ST_EMPTY, value: '0, position: '0, last: 1'b1};
          expected_q.push_back(r);
        end else begin
          idx = hist_count;
          while (idx > 0) begin
            idx = idx - 5'd1;
            r = '{status: hsdo_pkg::ST_OK, value: hist_mem[ring_slot(idx)], position: idx,
                  last: (idx == 0)};
            expected_q.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver: bursts with random gaps
  stack_op_t nxt;
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.mode  <= hsdo_pkg::MODE_PUSH;
      item_ch.entry <= '0;
      burst_left = 0;
      gap_left = 0;
      hist_count = '0;
      hist_oldest = '0;
    end else begin
      if (item_ch.valid && item_ch.ready) predict_stack(item_ch.mode, item_ch.entry);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0 || op_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          item_ch.valid <= 1'b0;
        end else begin
          nxt = op_q.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.mode  <= nxt.mode;
          item_ch.entry <= nxt.entry;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: stall styles that change every so often, plus one long hold-off
  int rx_style;
  int rx_left;
  int rx_transfers;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_style = 0;
      rx_left = 0;
      rx_transfers = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) rx_transfers++;
      if (!hold_done && rx_transfers >= 60) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_style = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 120);
        end else begin
          rx_left--;
        end
        case (rx_style)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ((rx_left % 5) != 0);
        endcase
      end
    end
  end

  // monitor
  stack_res_t got;
  stack_res_t want;

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{status: res_ch.status, value: res_ch.value, position: res_ch.position,
              last: res_ch.last};
      if (expected_q.size() == 0) begin
        report_error($sformatf("unexpected transfer status=%0d value=%h pos=%0d last=%0b",
                               got.status, got.value, got.position, got.last));
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_error($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.value !== want.value)
          report_error($sformatf("value %h, want %h", got.value, want.value));
        if (got.position !== want.position)
          report_error($sformatf("position %0d, want %0d", got.position, want.position));
        if (got.last !== want.last)
          report_error($sformatf("last %0b, want %0b", got.last, want.last));
      end
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_op(input logic [hsdo_pkg::MODE_W-1:0] md,
                        input logic [hsdo_pkg::ENTRY_W-1:0] word);
    stack_op_t t;
    t.mode = md;
    t.entry = word;
    op_q.push_back(t);
  endtask

  function automatic logic [hsdo_pkg::ENTRY_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic add_random_ops(input int n, input int push_pct);
    int done;
    int pick;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) add_op(MODE_NOP, rand_word());
      else if (pick < 8 + push_pct) add_op(hsdo_pkg::MODE_PUSH, rand_word());
      else if (pick < 88) add_op(hsdo_pkg::MODE_POP, rand_word());
      else add_op(hsdo_pkg::MODE_DUMP, rand_word());
      done++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (op_q.size() != 0 || item_ch.valid || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [hsdo_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hist_cap = v;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = hsdo_pkg::CAP_RESET;
    hist_cap = hsdo_pkg::CAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty stack, plain pushes, dump, pop, unused mode
    add_op(hsdo_pkg::MODE_POP, 32'hDEAD_BEEF);
    add_op(hsdo_pkg::MODE_DUMP, 32'hFFFF_FFFF);
    add_op(hsdo_pkg::MODE_PUSH, 32'h0000_0000);
    add_op(hsdo_pkg::MODE_PUSH, 32'hFFFF_FFFF);
    add_op(hsdo_pkg::MODE_PUSH, 32'hA5A5_A5A5);
    add_op(hsdo_pkg::MODE_DUMP, 32'h0000_0000);
    add_op(hsdo_pkg::MODE_POP, 32'h0000_0000);
    add_op(MODE_NOP, 32'hFFFF_FFFF);
    add_op(hsdo_pkg::MODE_PUSH, 32'h5A5A_5A5A);
    wait_idle();

    // capacity below the count: every push evicts
    set_capacity(5'd1);
    add_op(hsdo_pkg::MODE_PUSH, 32'h1234_5678);
    add_op(hsdo_pkg::MODE_DUMP, 32'h0000_0000);
    add_op(hsdo_pkg::MODE_POP, 32'h0000_0000);
    add_op(hsdo_pkg::MODE_POP, 32'h0000_0000);
    add_op(hsdo_pkg::MODE_POP, 32'h0000_0000);
    add_op(hsdo_pkg::MODE_POP, 32'h0000_0000);
    add_op(MODE_NOP, 32'h0000_0000);
    wait_idle();

    // zero capacity acts as one
    set_capacity(5'd0);
    add_op(hsdo_pkg::MODE_PUSH, 32'h8000_0001);
    add_op(hsdo_pkg::MODE_PUSH, 32'h7FFF_FFFE);
    add_op(hsdo_pkg::MODE_DUMP, 32'h0000_0000);
    add_op(hsdo_pkg::MODE_POP, 32'h0000_0000);
    wait_idle();

    set_capacity(5'd31);
    add_random_ops(36, 62);
    wait_idle();
    set_capacity(5'd16);
    add_random_ops(36, 50);
    wait_idle();
    set_capacity(5'd17);
    add_random_ops(36, 55);
    wait_idle();
    set_capacity(5'd4);
    add_random_ops(36, 45);
    wait_idle();
    set_capacity(5'd1);
    add_random_ops(36, 40);
    wait_idle();
    set_capacity(5'd0);
    add_random_ops(36, 45);
    wait_idle();
    set_capacity(5'd8);
    add_random_ops(36, 35);
    wait_idle();
    set_capacity(5'($urandom_range(0, 31)));
    add_random_ops(36, 55);
    wait_idle();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
